// File: sv/mbp_pkg.sv
// shared types and constants of the message bit packer
package mbp_pkg;

  localparam int MBP_MAX_BYTES = 4096;
  localparam int ACT_W         = 3;
  localparam int VAL_W         = 32;
  localparam int BCNT_W        = 6;
  localparam int ADDR_W        = 12;
  localparam int RD_W          = 8;
  localparam int CNT_W         = 13;
  localparam int BITS_W        = 16;

  typedef enum logic [ACT_W-1:0] {
    ACT_CLEAR = 3'd0,
    ACT_BIT   = 3'd1,
    ACT_BITS  = 3'd2,
    ACT_BYTE  = 3'd3,
    ACT_SHORT = 3'd4,
    ACT_INT   = 3'd5,
    ACT_READ  = 3'd6
  } mbp_action_e;

  typedef struct packed {
    logic load;
    logic step;
    logic res_load;
  } mbp_cmd_t;

  typedef struct packed {
    logic has_writes;
    logic last_write;
  } mbp_sts_t;

endpackage

// File: sv/mbp_ram.sv
// generic single write port ram with registered read
module mbp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: sv/mbp_ctrl.sv
// controller state machine of the message bit packer
module mbp_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  input  mbp_pkg::mbp_sts_t sts_i,
  output mbp_pkg::mbp_cmd_t cmd_o
);
  import mbp_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_WRITE,
    S_FIN
  } state_e;

  state_e state_q;
  logic   out_valid_q;

  always_comb begin
    cmd_o.load     = (state_q == S_IDLE) && in_valid_i;
    cmd_o.step     = (state_q == S_WRITE);
    cmd_o.res_load = (state_q == S_FIN) && (!out_valid_q || !out_stall_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            state_q <= sts_i.has_writes ? S_WRITE : S_FIN;
          end
        end
        S_WRITE: begin
          if (sts_i.last_write) begin
            state_q <= S_FIN;
          end
        end
        S_FIN: begin
          if (cmd_o.res_load) begin
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
      if (cmd_o.res_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

// File: sv/mbp_dpath.sv
// datapath of the message bit packer: counters, byte sequencer, store, result register
module mbp_dpath #(
  parameter int MAX_BYTES = mbp_pkg::MBP_MAX_BYTES
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [mbp_pkg::CNT_W-1:0]   cfg_wdata_i,
  input  logic [mbp_pkg::ACT_W-1:0]   action_i,
  input  logic [mbp_pkg::VAL_W-1:0]   value_i,
  input  logic [mbp_pkg::BCNT_W-1:0]  bit_count_i,
  input  logic [mbp_pkg::ADDR_W-1:0]  address_i,
  input  mbp_pkg::mbp_cmd_t           cmd_i,
  output mbp_pkg::mbp_sts_t           sts_o,
  output logic [mbp_pkg::RD_W-1:0]    read_data_o,
  output logic [mbp_pkg::CNT_W-1:0]   byte_count_o,
  output logic [mbp_pkg::BITS_W-1:0]  bits_used_o,
  output logic                        overflow_o
);
  import mbp_pkg::*;

  localparam int AW = $clog2(MAX_BYTES);
  localparam logic [CNT_W-1:0] LIM_CAP =
    CNT_W'((MAX_BYTES > (2**CNT_W - 1)) ? (2**CNT_W - 1) : MAX_BYTES);
  localparam logic [16:0] MAX_ADDR = 17'(MAX_BYTES);

  // architectural state
  logic [CNT_W-1:0]  used_q, size_limit_q;
  logic [BITS_W-1:0] bp_q;
  logic              ovf_q;
  logic [7:0]        partial_q;
  // byte sequencer
  logic [39:0]       sr_q;
  logic [CNT_W-1:0]  addr_q, nxt_q;
  logic [2:0]        cnt_q;
  logic              bitmode_q, isrd_q;
  // result register
  logic [RD_W-1:0]   res_rd_q;
  logic [CNT_W-1:0]  res_bc_q;
  logic [BITS_W-1:0] res_bits_q;
  logic              res_ovf_q;

  logic [CNT_W-1:0]  lim;
  logic [2:0]        off;
  logic              bnd, do_bits, room, rd_ok;
  logic [5:0]        cnt_c, c, t, rem;
  logic [2:0]        nbyte, nw_bits, nb_bits, wr_n;
  logic [31:0]       vmask, vm;
  logic [39:0]       stream, wr_sr;
  logic [BITS_W-1:0] bp_bits;
  logic [CNT_W-1:0]  wr_addr, wr_nxt, used_inc;
  logic [RD_W-1:0]   ram_rdata;

  always_comb begin
    lim     = (size_limit_q < LIM_CAP) ? size_limit_q : LIM_CAP;
    off     = bp_q[2:0];
    bnd     = (off == 3'd0);
    cnt_c   = (bit_count_i > 6'd32) ? 6'd32 : bit_count_i;
    do_bits = 1'b0;
    c       = cnt_c;
    nbyte   = 3'd0;
    room    = 1'b1;
    case (action_i)
      ACT_BIT: begin
        do_bits = 1'b1;
        c       = 6'd1;
        room    = !(bnd && (used_q >= lim));
      end
      ACT_BITS: begin
        do_bits = 1'b1;
        room    = ({1'b0, used_q} + 14'd4) <= {1'b0, lim};
      end
      ACT_BYTE:  nbyte = 3'd1;
      ACT_SHORT: nbyte = 3'd2;
      ACT_INT:   nbyte = 3'd4;
      default: ;
    endcase
    if (nbyte != 3'd0) begin
      room = ({1'b0, used_q} + {11'd0, nbyte}) <= {1'b0, lim};
    end

    vmask   = c[5] ? 32'hFFFF_FFFF : ((32'd1 << c[4:0]) - 32'd1);
    vm      = value_i & vmask;
    t       = {3'd0, off} + c;
    // bytes touched, first one being the partly filled byte when off is nonzero
    nw_bits = (c == 6'd0) ? 3'd0 : 3'((t + 6'd7) >> 3);
    nb_bits = (c == 6'd0) ? 3'd0 : (bnd ? nw_bits : nw_bits - 3'd1);
    rem     = bnd ? t : t - 6'd8;
    bp_bits = (nb_bits == 3'd0) ? bp_q + {10'd0, c} : {used_q, 3'b000} + {10'd0, rem};
    stream  = bnd ? {8'd0, vm} : (({8'd0, vm} << off) | {32'd0, partial_q});

    if (do_bits) begin
      wr_n     = nw_bits;
      wr_sr    = stream;
      wr_addr  = bnd ? used_q : bp_q[BITS_W-1:3];
      wr_nxt   = bnd ? used_q + 13'd1 : used_q;
      used_inc = used_q + {10'd0, nb_bits};
    end else begin
      wr_n     = nbyte;
      wr_sr    = {8'd0, value_i};
      wr_addr  = used_q;
      wr_nxt   = used_q + 13'd1;
      used_inc = used_q + {10'd0, nbyte};
    end
    if (!room) begin
      wr_n = 3'd0;
    end

    rd_ok = {5'd0, address_i} < MAX_ADDR;
  end

  assign sts_o.has_writes = (wr_n != 3'd0);
  assign sts_o.last_write = (cnt_q == 3'd1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q       <= '0;
      bp_q         <= '0;
      ovf_q        <= 1'b0;
      size_limit_q <= CNT_W'(MBP_MAX_BYTES);
      cnt_q        <= '0;
    end else begin
      if (cfg_we_i) begin
        size_limit_q <= cfg_wdata_i;
      end
      if (cmd_i.load) begin
        cnt_q <= wr_n;
        if (action_i == ACT_CLEAR) begin
          used_q <= '0;
          bp_q   <= '0;
          ovf_q  <= 1'b0;
        end else if (do_bits || (nbyte != 3'd0)) begin
          if (!room) begin
            ovf_q <= 1'b1;
          end else begin
            used_q <= used_inc;
            if (do_bits) begin
              bp_q <= bp_bits;
            end
          end
        end
      end else if (cmd_i.step) begin
        cnt_q <= cnt_q - 3'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      sr_q      <= wr_sr;
      addr_q    <= wr_addr;
      nxt_q     <= wr_nxt;
      bitmode_q <= do_bits;
      isrd_q    <= (action_i == ACT_READ) && rd_ok;
    end else if (cmd_i.step) begin
      sr_q   <= sr_q >> 8;
      addr_q <= nxt_q;
      nxt_q  <= nxt_q + 13'd1;
      // the last byte of a bit field write is the one left partly filled
      if (bitmode_q) begin
        partial_q <= sr_q[7:0];
      end
    end
    if (cmd_i.res_load) begin
      res_rd_q   <= isrd_q ? ram_rdata : '0;
      res_bc_q   <= used_q;
      res_bits_q <= {used_q, 3'b000} - {13'd0, 3'(3'd0 - off)};
      res_ovf_q  <= ovf_q;
    end
  end

  mbp_ram #(
    .WIDTH(RD_W),
    .DEPTH(MAX_BYTES)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (cmd_i.step),
    .waddr_i(AW'({4'd0, addr_q})),
    .wdata_i(sr_q[7:0]),
    .re_i   (cmd_i.load && (action_i == ACT_READ) && rd_ok),
    .raddr_i(AW'({5'd0, address_i})),
    .rdata_o(ram_rdata)
  );

  assign read_data_o  = res_rd_q;
  assign byte_count_o = res_bc_q;
  assign bits_used_o  = res_bits_q;
  assign overflow_o   = res_ovf_q;

endmodule

// File: sv/message_bit_packer_unit.sv
// message bit packer top level: lsb-first bit fields and little-endian words in a byte store
// Builds a message in a MAX_BYTES deep byte store, one action per item, one result
// per item. Clear, read byte and a write that lacks room store no byte; a byte stores 1,
// a short 2, an int 4 and a bit field 0 to 5, through the store's single write port
// which takes one byte per cycle. A finished result sits in an output register, so the
// next item is taken while it waits. The store is not cleared at reset; its contents
// are undefined until written, and each byte is written before a read can reach it in
// normal use. size_limit resets to 4096; the user must write it only between items,
// and the block itself does not enforce this.
module message_bit_packer_unit #(
  parameter int MAX_BYTES = mbp_pkg::MBP_MAX_BYTES
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [mbp_pkg::CNT_W-1:0]   cfg_wdata_i,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [mbp_pkg::ACT_W-1:0]   action_i,
  input  logic [mbp_pkg::VAL_W-1:0]   value_i,
  input  logic [mbp_pkg::BCNT_W-1:0]  bit_count_i,
  input  logic [mbp_pkg::ADDR_W-1:0]  address_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [mbp_pkg::RD_W-1:0]    read_data_o,
  output logic [mbp_pkg::CNT_W-1:0]   byte_count_o,
  output logic [mbp_pkg::BITS_W-1:0]  bits_used_o,
  output logic                        overflow_o
);
  import mbp_pkg::*;

  mbp_cmd_t cmd;
  mbp_sts_t sts;

  mbp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  mbp_dpath #(
    .MAX_BYTES(MAX_BYTES)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .action_i    (action_i),
    .value_i     (value_i),
    .bit_count_i (bit_count_i),
    .address_i   (address_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .read_data_o (read_data_o),
    .byte_count_o(byte_count_o),
    .bits_used_o (bits_used_o),
    .overflow_o  (overflow_o)
  );

  // the message never grows past the store
  a_count_in_store: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ({4'd0, byte_count_o} <= 17'(MAX_BYTES)))
    else $error("byte count beyond store depth");

  // bits used never exceed the whole bytes taken, and lag them by under a byte
  a_bits_vs_bytes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((bits_used_o <= {byte_count_o, 3'b000}) &&
                     ({byte_count_o, 3'b000} - bits_used_o < 16'd8)))
    else $error("bits used inconsistent with byte count");

  // an accepted item locks the input until its result is loaded into the output register
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input open right after an accepted item");

  // the store is written only while an item is in flight
  a_store_writes_only_when_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.step |-> in_stall_o)
    else $error("store written while idle");

endmodule

// File: dv/message_bit_packer_unit_tb.sv
// self-checking testbench of the message bit packer: directed table, then random phases
`timescale 1ns / 100ps

module message_bit_packer_unit_tb;
  import mbp_pkg::*;

  localparam logic [ACT_W-1:0] ACT_UNUSED = 3'd7;
  localparam int N_DIRECTED    = 25;
  localparam int N_PHASES      = 5;
  localparam int HOLD_CYCLES   = 100;
  localparam int STUCK_LIMIT   = 4000;
  localparam int SETTLE_CYCLES = 16;
  localparam int REPORT_MAX    = 10;

  typedef struct packed {
    logic [RD_W-1:0]   read_data;
    logic [CNT_W-1:0]  byte_count;
    logic [BITS_W-1:0] bits_used;
    logic              overflow;
  } pack_result_t;

  typedef struct packed {
    logic               is_cfg;
    logic [ACT_W-1:0]   action;
    logic [VAL_W-1:0]   value;
    logic [BCNT_W-1:0]  bit_count;
    logic [ADDR_W-1:0]  address;
    logic               fixed;
    pack_result_t       want;
  } stim_row_t;

  typedef enum logic { MIX_ALL, MIX_FILL } traffic_mix_e;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_we_i = 1'b0;
  logic [CNT_W-1:0]   cfg_wdata_i = '0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  logic [ACT_W-1:0]   action_i = '0;
  logic [VAL_W-1:0]   value_i = '0;
  logic [BCNT_W-1:0]  bit_count_i = '0;
  logic [ADDR_W-1:0]  address_i = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic [RD_W-1:0]    read_data_o;
  logic [CNT_W-1:0]   byte_count_o;
  logic [BITS_W-1:0]  bits_used_o;
  logic               overflow_o;

  // tag that travels with the item on the input side
  logic               item_fixed = 1'b0;
  pack_result_t       item_want = '0;

  logic quiet_run = 1'b0;
  logic hold_req = 1'b0;
  logic hold_used = 1'b0;
  int   hold_left = 0;

  // shadow of the packer state
  logic [7:0] shadow_msg [MBP_MAX_BYTES];
  int         shadow_fill = 0;
  int         shadow_bitpos = 0;
  logic       shadow_ovf = 1'b0;
  int         shadow_limit = MBP_MAX_BYTES;
  int         shadow_peak = 0;

  pack_result_t pending_reports [$];

  int items_taken = 0;
  int reports_seen = 0;
  int overflow_reports = 0;
  int mismatch_count = 0;
  int limit_writes = 0;
  int stuck_cycles = 0;

  stim_row_t directed_rows [N_DIRECTED];

  message_bit_packer_unit dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .action_i     (action_i),
    .value_i      (value_i),
    .bit_count_i  (bit_count_i),
    .address_i    (address_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .read_data_o  (read_data_o),
    .byte_count_o (byte_count_o),
    .bits_used_o  (bits_used_o),
    .overflow_o   (overflow_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic void append_bit(input logic b);
    // a fresh zeroed byte is taken only on a byte boundary
    if (shadow_bitpos % 8 == 0) begin
      shadow_bitpos = shadow_fill * 8;
      shadow_msg[shadow_fill] = 8'h00;
      shadow_fill++;
    end
    if (b) shadow_msg[shadow_bitpos / 8][shadow_bitpos % 8] = 1'b1;
    shadow_bitpos++;
  endfunction

  function automatic void append_le(input logic [VAL_W-1:0] v, input int n);
    if (shadow_fill + n > shadow_limit) begin
      shadow_ovf = 1'b1;
    end else begin
      for (int i = 0; i < n; i++) shadow_msg[shadow_fill + i] = v[8*i +: 8];
      shadow_fill += n;
    end
  endfunction

  function automatic pack_result_t predict_packer_result(
    input logic [ACT_W-1:0]  action,
    input logic [VAL_W-1:0]  value,
    input logic [BCNT_W-1:0] bit_count,
    input logic [ADDR_W-1:0] address
  );
    pack_result_t r;
    int n;
    int used_bits;
    r = '0;
    case (action)
      ACT_CLEAR: begin
        shadow_fill = 0;
        shadow_bitpos = 0;
        shadow_ovf = 1'b0;
      end
      ACT_BIT: begin
        if (shadow_bitpos % 8 == 0 && shadow_fill >= shadow_limit) shadow_ovf = 1'b1;
        else append_bit(value[0]);
      end
      ACT_BITS: begin
        // room for four bytes is needed whatever the count
        if (shadow_fill + 4 > shadow_limit) begin
          shadow_ovf = 1'b1;
        end else begin
          n = (bit_count > 32) ? 32 : int'(bit_count);
          for (int i = 0; i < n; i++) append_bit(value[i]);
        end
      end
      ACT_BYTE:  append_le(value, 1);
      ACT_SHORT: append_le(value, 2);
      ACT_INT:   append_le(value, 4);
      ACT_READ:  if (address < MBP_MAX_BYTES) r.read_data = shadow_msg[address];
      default: ;
    endcase
    used_bits = shadow_fill * 8 - ((8 - shadow_bitpos % 8) % 8);
    r.byte_count = shadow_fill[CNT_W-1:0];
    r.bits_used = used_bits[BITS_W-1:0];
    r.overflow = shadow_ovf;
    if (shadow_fill > shadow_peak) shadow_peak = shadow_fill;
    return r;
  endfunction

  function automatic stim_row_t pred_row(input logic [ACT_W-1:0] action,
                                         input logic [VAL_W-1:0] value,
                                         input logic [BCNT_W-1:0] bit_count,
                                         input logic [ADDR_W-1:0] address);
    stim_row_t s;
    s = '0;
    s.action = action;
    s.value = value;
    s.bit_count = bit_count;
    s.address = address;
    return s;
  endfunction

  function automatic stim_row_t fixed_row(input logic [ACT_W-1:0] action,
                                          input logic [VAL_W-1:0] value,
                                          input logic [BCNT_W-1:0] bit_count,
                                          input logic [ADDR_W-1:0] address,
                                          input logic [RD_W-1:0] rd,
                                          input logic [CNT_W-1:0] bc,
                                          input logic [BITS_W-1:0] bu,
                                          input logic ov);
    stim_row_t s;
    s = pred_row(action, value, bit_count, address);
    s.fixed = 1'b1;
    s.want = '{rd, bc, bu, ov};
    return s;
  endfunction

  function automatic stim_row_t limit_row(input int lim);
    stim_row_t s;
    s = '0;
    s.is_cfg = 1'b1;
    s.value = lim;
    return s;
  endfunction

  function automatic stim_row_t random_row(input traffic_mix_e mix);
    stim_row_t s;
    int pick;
    s = pred_row(ACT_CLEAR, $urandom, 6'($urandom), 12'($urandom));
    pick = $urandom_range(0, 99);
    if (mix == MIX_FILL) begin
      if (pick < 12)      s.action = ACT_BIT;
      else if (pick < 30) s.action = ACT_BITS;
      else if (pick < 40) s.action = ACT_BYTE;
      else if (pick < 50) s.action = ACT_SHORT;
      else if (pick < 88) s.action = ACT_INT;
      else if (pick < 97) s.action = ACT_READ;
      else                s.action = ACT_UNUSED;
    end else begin
      if (pick < 4)       s.action = ACT_CLEAR;
      else if (pick < 19) s.action = ACT_BIT;
      else if (pick < 44) s.action = ACT_BITS;
      else if (pick < 58) s.action = ACT_BYTE;
      else if (pick < 70) s.action = ACT_SHORT;
      else if (pick < 83) s.action = ACT_INT;
      else if (pick < 97) s.action = ACT_READ;
      else                s.action = ACT_UNUSED;
    end
    if (s.action == ACT_BITS)
      s.bit_count = ($urandom_range(0, 99) < 85) ? 6'($urandom_range(0, 32))
                                                  : 6'($urandom_range(33, 63));
    // reads stay inside the part of the store that has been written
    if (s.action == ACT_READ) begin
      if (shadow_peak > 0) s.address = 12'($urandom_range(0, shadow_peak - 1));
      else s.action = ACT_CLEAR;
    end
    return s;
  endfunction

  task automatic offer_item(input stim_row_t s);
    while (!quiet_run && $urandom_range(0, 99) < 19) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    action_i    <= s.action;
    value_i     <= s.value;
    bit_count_i <= s.bit_count;
    address_i   <= s.address;
    item_fixed  <= s.fixed;
    item_want   <= s.want;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task automatic write_limit(input int lim);
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending_reports.size() != 0);
    repeat (8) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= lim[CNT_W-1:0];
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    shadow_limit = (lim < MBP_MAX_BYTES) ? lim : MBP_MAX_BYTES;
    limit_writes++;
  endtask

  // input side: every accepted item gets its expectation
  always @(posedge clk_i) begin
    pack_result_t p;
    if (rst_ni && in_valid_i && !in_stall_o) begin
      p = predict_packer_result(action_i, value_i, bit_count_i, address_i);
      pending_reports.push_back(item_fixed ? item_want : p);
      items_taken++;
    end
  end

  // output side
  always @(posedge clk_i) begin
    pack_result_t got;
    pack_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got = '{read_data_o, byte_count_o, bits_used_o, overflow_o};
      reports_seen++;
      if (overflow_o) overflow_reports++;
      if (pending_reports.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= REPORT_MAX)
          $display("%0t: result with nothing expected: rd %0h cnt %0d bits %0d ovf %0b",
                   $realtime, read_data_o, byte_count_o, bits_used_o, overflow_o);
      end else begin
        want = pending_reports.pop_front();
        if (got.read_data !== want.read_data || got.byte_count !== want.byte_count ||
            got.bits_used !== want.bits_used || got.overflow !== want.overflow) begin
          mismatch_count++;
          if (mismatch_count <= REPORT_MAX)
            $display("%0t: mismatch exp rd %0h cnt %0d bits %0d ovf %0b, got rd %0h cnt %0d bits %0d ovf %0b",
                     $realtime, want.read_data, want.byte_count, want.bits_used,
                     want.overflow, got.read_data, got.byte_count, got.bits_used,
                     got.overflow);
        end
      end
    end
  end

  // receiver: one long hold-off, otherwise random stalls except in quiet phases
  always @(posedge clk_i) begin
    if (hold_left != 0) begin
      out_stall_i <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_req && !hold_used) begin
      out_stall_i <= 1'b1;
      hold_left <= HOLD_CYCLES;
      hold_used <= 1'b1;
    end else begin
      out_stall_i <= !quiet_run && ($urandom_range(0, 99) < 19);
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles >= STUCK_LIMIT) begin
      $display("no progress for %0d cycles", STUCK_LIMIT);
      $display("tb: failure");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  initial begin
    int phase_limit [N_PHASES];
    int phase_items [N_PHASES];
    traffic_mix_e phase_mix [N_PHASES];
    logic phase_quiet [N_PHASES];
    logic phase_hold [N_PHASES];

    directed_rows = '{
      fixed_row(ACT_CLEAR, 32'h0, 6'd0, 12'd0, 8'd0, 13'd0, 16'd0, 1'b0),
      fixed_row(ACT_BIT, 32'h1, 6'd0, 12'd0, 8'd0, 13'd1, 16'd1, 1'b0),
      pred_row(ACT_BITS, 32'hFFFF_FFFF, 6'd32, 12'd0),
      pred_row(ACT_BITS, 32'h0, 6'd0, 12'd0),
      pred_row(ACT_BITS, 32'hA5A5_5A5A, 6'd63, 12'd0),   // count above 32
      pred_row(ACT_BYTE, 32'hDEAD_BEFF, 6'd0, 12'd0),
      pred_row(ACT_SHORT, 32'hFFFF_1234, 6'd0, 12'd0),
      pred_row(ACT_INT, 32'hFFFF_FFFF, 6'd0, 12'd0),
      pred_row(ACT_INT, 32'h0, 6'd0, 12'd0),
      pred_row(ACT_BIT, 32'h0, 6'd0, 12'd0),             // back into the partial byte
      pred_row(ACT_READ, 32'h0, 6'd0, 12'd0),
      pred_row(ACT_READ, 32'hFFFF_FFFF, 6'd63, 12'd1),
      pred_row(ACT_READ, 32'h0, 6'd0, 12'd4),
      pred_row(ACT_UNUSED, 32'hFFFF_FFFF, 6'd63, 12'hFFF),
      limit_row(1),
      fixed_row(ACT_CLEAR, 32'h0, 6'd0, 12'd0, 8'd0, 13'd0, 16'd0, 1'b0),
      fixed_row(ACT_BYTE, 32'h5A, 6'd0, 12'd0, 8'd0, 13'd1, 16'd8, 1'b0),
      fixed_row(ACT_BYTE, 32'hA5, 6'd0, 12'd0, 8'd0, 13'd1, 16'd8, 1'b1),
      fixed_row(ACT_BIT, 32'h1, 6'd0, 12'd0, 8'd0, 13'd1, 16'd8, 1'b1),
      fixed_row(ACT_CLEAR, 32'h0, 6'd0, 12'd0, 8'd0, 13'd0, 16'd0, 1'b0),
      // field write needs four free bytes even for one bit
      fixed_row(ACT_BITS, 32'h1, 6'd1, 12'd0, 8'd0, 13'd0, 16'd0, 1'b1),
      fixed_row(ACT_BIT, 32'h1, 6'd0, 12'd0, 8'd0, 13'd1, 16'd1, 1'b1),
      fixed_row(ACT_READ, 32'h0, 6'd0, 12'd0, 8'd1, 13'd1, 16'd1, 1'b1),
      limit_row(MBP_MAX_BYTES),
      fixed_row(ACT_CLEAR, 32'h0, 6'd0, 12'd0, 8'd0, 13'd0, 16'd0, 1'b0)
    };

    // the fourth phase lowers the limit under what the fill phase left behind
    phase_limit = '{MBP_MAX_BYTES, 1, MBP_MAX_BYTES, $urandom_range(2, 64),
                    $urandom_range(1, MBP_MAX_BYTES)};
    phase_items = '{150, 40, 120, 60, 180};
    phase_mix   = '{MIX_ALL, MIX_ALL, MIX_FILL, MIX_ALL, MIX_ALL};
    phase_quiet = '{1'b0, 1'b0, 1'b1, 1'b0, 1'b0};
    phase_hold  = '{1'b1, 1'b0, 1'b0, 1'b0, 1'b0};

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i]) begin
      if (directed_rows[i].is_cfg) write_limit(int'(directed_rows[i].value));
      else offer_item(directed_rows[i]);
    end

    for (int p = 0; p < N_PHASES; p++) begin
      write_limit(phase_limit[p]);
      quiet_run <= phase_quiet[p];
      hold_req  <= phase_hold[p];
      for (int k = 0; k < phase_items[p]; k++) offer_item(random_row(phase_mix[p]));
    end

    in_valid_i <= 1'b0;
    quiet_run  <= 1'b0;
    do @(posedge clk_i); while (pending_reports.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (pending_reports.size() != 0) mismatch_count++;

    $display("summary: %0d items over %0d limit settings, %0d results checked, %0d with overflow",
             items_taken, limit_writes, reports_seen, overflow_reports);
    $display("summary: message grew to %0d bytes at most, %0d mismatches",
             shadow_peak, mismatch_count);
    if (mismatch_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// File: sim.f
sv/mbp_pkg.sv
sv/mbp_ram.sv
sv/mbp_ctrl.sv
sv/mbp_dpath.sv
sv/message_bit_packer_unit.sv
dv/message_bit_packer_unit_tb.sv
